// File: sv/tempo_est_pkg.sv
// ----------------------------------------------------------------------------
// Tempo estimator package
// Shared widths, constants, register indexes, beat offset table and the
// request and response types of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tempo_est_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int TEMPO_W    = 9;
   localparam int COUNT_W    = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int TEMPO_Q4_W = 13;
   localparam int ENERGY_W   = 24;
   localparam int LEVEL_W    = 33;
   localparam int LEVEL_FRAC = 9;
   localparam int IVAL_W     = 25;
   localparam int SUM_W      = 48;
   localparam int RAND_W     = 48;
   localparam int MUL_W      = 24;
   localparam int DD_W       = 35;
   localparam int DV_W       = 25;
   localparam int POS_FRAC   = 18;

   localparam int DEF_ENERGY_DEPTH = 65536;
   localparam int DEF_DECIMATION   = 128;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOWEST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FASTEST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBES  = 2'd3;

   localparam logic [TEMPO_W-1:0] RST_SLOWEST = 9'd72;
   localparam logic [TEMPO_W-1:0] RST_FASTEST = 9'd168;
   localparam logic [COUNT_W-1:0] RST_STEPS   = 13'd1024;
   localparam logic [COUNT_W-1:0] RST_PROBES  = 13'd1024;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [RAND_W-1:0] RAND_SEED  = 48'h1234ABCD330E;
   localparam logic [MUL_W-1:0]  LCG_MUL_LO = 24'hECE66D;
   localparam logic [MUL_W-1:0]  LCG_MUL_HI = 24'h0005DE;
   localparam logic [RAND_W-1:0] LCG_ADD    = 48'hB;

   localparam logic [DD_W-1:0]   IVAL_DIVIDEND  = 35'd1354752000;
   localparam logic [DD_W-1:0]   TEMPO_DIVIDEND = 35'd21676032000;
   localparam logic [IVAL_W-1:0] IVAL_MAX       = 25'h1FFFFFF;
   localparam logic [SUM_W-1:0]  SUM_MAX        = 48'h7FFFFFFFFFFF;

   localparam int TERM_W    = 5;
   localparam int NUM_TERMS = 17;

   typedef struct packed {
      logic       center;
      logic       neg;
      logic [2:0] shift;
      logic       penalty;
   } term_type;

   // Term 0 is the probe center, terms 1..12 are the beat multiples and
   // terms 13..16 are the quarter and half beat offsets, which subtract.
   function automatic term_type term_info(input logic [TERM_W-1:0] j);
      term_type t;
      t = '{center: 1'b0, neg: 1'b0, shift: 3'd0, penalty: 1'b0};
      case (j)
         5'd0:    t.center = 1'b1;
         5'd1:    begin t.neg = 1'b1; t.shift = 3'd7; end
         5'd2:    begin t.neg = 1'b1; t.shift = 3'd6; end
         5'd3:    begin t.neg = 1'b1; t.shift = 3'd5; end
         5'd4:    begin t.neg = 1'b1; t.shift = 3'd4; end
         5'd5:    begin t.neg = 1'b1; t.shift = 3'd3; end
         5'd6:    begin t.neg = 1'b1; t.shift = 3'd2; end
         5'd7:    t.shift = 3'd2;
         5'd8:    t.shift = 3'd3;
         5'd9:    t.shift = 3'd4;
         5'd10:   t.shift = 3'd5;
         5'd11:   t.shift = 3'd6;
         5'd12:   t.shift = 3'd7;
         5'd13:   begin t.neg = 1'b1; t.shift = 3'd1; t.penalty = 1'b1; end
         5'd14:   begin t.neg = 1'b1; t.shift = 3'd0; t.penalty = 1'b1; end
         5'd15:   begin t.shift = 3'd0; t.penalty = 1'b1; end
         5'd16:   begin t.shift = 3'd1; t.penalty = 1'b1; end
         default: t.center = 1'b1;
      endcase
      return t;
   endfunction

   typedef struct packed {
      logic            start;
      logic [DD_W-1:0] dividend;
      logic [DV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [DD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: sv/tempo_est_ram.sv
// ----------------------------------------------------------------------------
// Tempo estimator RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_est_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/tempo_est_div.sv
// ----------------------------------------------------------------------------
// Tempo estimator divider
// Restoring divider shared by the interval, step and tempo conversions; one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_est_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tempo_est_pkg::div_req_type div_req,
   output tempo_est_pkg::div_rsp_type      div_rsp
);

   import tempo_est_pkg::*;

   localparam int CNT_W = $clog2(DD_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DV_W-1:0]  rem_ff;
   logic [DV_W-1:0]  dvs_ff;
   logic [DD_W-1:0]  quo_ff;

   logic [DV_W:0]    trial;
   logic [DV_W:0]    diff;
   logic             ge;
   logic [DV_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = (trial >= {1'b0, dvs_ff});
      rem_in = ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         cnt_ff <= CNT_W'(DD_W - 1);
         rem_ff <= '0;
         dvs_ff <= div_req.divisor;
         quo_ff <= div_req.dividend;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DD_W-2:0], ge};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// File: sv/tempo_est_meter.sv
// ----------------------------------------------------------------------------
// Tempo estimator peak meter
// Peak meter with fast attack and slow decay, decimation counter and the
// append logic of the energy store.
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_est_meter #(
   parameter int ENERGY_DEPTH = tempo_est_pkg::DEF_ENERGY_DEPTH,
   parameter int DECIMATION   = tempo_est_pkg::DEF_DECIMATION
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    sample_valid,
   input  wire logic signed [tempo_est_pkg::SAMPLE_W-1:0] sample,
   output logic                                         wr_en,
   output logic [$clog2(ENERGY_DEPTH)-1:0]              wr_addr,
   output logic [tempo_est_pkg::ENERGY_W-1:0]           wr_data,
   output logic [$clog2(ENERGY_DEPTH+1)-1:0]            energy_count,
   output logic                                         overflow
);

   import tempo_est_pkg::*;

   localparam int AW = $clog2(ENERGY_DEPTH);
   localparam int CW = $clog2(ENERGY_DEPTH + 1);
   localparam int PW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

   logic [LEVEL_W-1:0]  level_ff;
   logic [LEVEL_W-1:0]  level_in;
   logic [PW-1:0]       phase_ff;
   logic                store_pend_ff;
   logic [CW-1:0]       count_ff;
   logic                overflow_ff;

   logic [SAMPLE_W-1:0] mag;
   logic [LEVEL_W-1:0]  target;
   logic                full;

   always_comb begin
      // The most negative sample maps onto 2^23, which still fits unsigned.
      mag    = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
      target = {mag, {LEVEL_FRAC{1'b0}}};
      if (target > level_ff) begin
         level_in = level_ff + ((target - level_ff) >> 3);
      end else begin
         level_in = level_ff - ((level_ff - target) >> 9);
      end
   end

   assign full = (count_ff == CW'(ENERGY_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         phase_ff      <= '0;
         store_pend_ff <= 1'b0;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         store_pend_ff <= 1'b0;
         if (sample_valid) begin
            level_ff <= level_in;
            if (phase_ff == PW'(DECIMATION - 1)) begin
               phase_ff      <= '0;
               store_pend_ff <= 1'b1;
            end else begin
               phase_ff <= phase_ff + 1'b1;
            end
         end
         // The store write comes in the cycle after the level update.
         if (store_pend_ff) begin
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   assign wr_en        = store_pend_ff && !full;
   assign wr_addr      = count_ff[AW-1:0];
   assign wr_data      = level_ff[LEVEL_W-1:LEVEL_FRAC];
   assign energy_count = count_ff;
   assign overflow     = overflow_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENERGY_DEPTH))
      else $error("energy count beyond store depth");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> $past(count_ff) == CW'(ENERGY_DEPTH))
      else $error("overflow raised while store not full");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("store write did not advance the count");
`endif

endmodule

`default_nettype wire

// File: sv/tempo_estimator_core.sv
// Sample transfers: a new sample every cycle while the sequencer is idle; no result.
// Finish transfer: the shared divider runs up to four divisions, then each
// interval makes multiplier passes for the generator and probe center, and
// each probe term reads the store through an address and a data state.
// Synchronous reset clears control state; the energy store is not cleared.
// ----------------------------------------------------------------------------
// Tempo estimator core
// Peak meter feeding an energy store, and a sequencer that scans beat
// intervals with a shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_estimator_core #(
   parameter int ENERGY_DEPTH = tempo_est_pkg::DEF_ENERGY_DEPTH,
   parameter int DECIMATION   = tempo_est_pkg::DEF_DECIMATION
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire logic                                        req_command,
   input  wire logic signed [tempo_est_pkg::SAMPLE_W-1:0]   req_audio_sample,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output logic [tempo_est_pkg::TEMPO_Q4_W-1:0]             rsp_tempo_q4,
   output logic                                             rsp_store_overflowed,
   input  wire logic                                        csr_write_enable,
   input  wire logic [tempo_est_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [tempo_est_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   import tempo_est_pkg::*;

   localparam int AW    = $clog2(ENERGY_DEPTH);
   localparam int CW    = $clog2(ENERGY_DEPTH + 1);
   localparam int MID_W = CW + 16;
   localparam int POS_W = ((CW + POS_FRAC > IVAL_W + 7) ? CW + POS_FRAC : IVAL_W + 7) + 2;
   localparam int IDX_W = POS_W - POS_FRAC;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DIV_GO   = 5'd1;
   localparam logic [4:0] S_DIV_WAIT = 5'd2;
   localparam logic [4:0] S_INTERVAL = 5'd3;
   localparam logic [4:0] S_LCG0     = 5'd4;
   localparam logic [4:0] S_LCG1     = 5'd5;
   localparam logic [4:0] S_LCG2     = 5'd6;
   localparam logic [4:0] S_LCG3     = 5'd7;
   localparam logic [4:0] S_MID0     = 5'd8;
   localparam logic [4:0] S_MID1     = 5'd9;
   localparam logic [4:0] S_MID2     = 5'd10;
   localparam logic [4:0] S_FADDR    = 5'd11;
   localparam logic [4:0] S_FDATA    = 5'd12;
   localparam logic [4:0] S_CLOSE    = 5'd13;
   localparam logic [4:0] S_FINAL    = 5'd14;
   localparam logic [4:0] S_DONE     = 5'd15;

   localparam logic [1:0] OP_SLOW  = 2'd0;
   localparam logic [1:0] OP_FAST  = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;
   localparam logic [1:0] OP_TEMPO = 2'd3;

   // Configuration registers
   logic [TEMPO_W-1:0]    slowest_ff;
   logic [TEMPO_W-1:0]    fastest_ff;
   logic [COUNT_W-1:0]    steps_ff;
   logic [COUNT_W-1:0]    probes_ff;

   // Sequencer state
   logic [4:0]            state_ff;
   logic [1:0]            div_op_ff;
   logic [IVAL_W-1:0]     slow_i_ff;
   logic [IVAL_W-1:0]     fast_i_ff;
   logic [IVAL_W-1:0]     step_ff;
   logic [IVAL_W-1:0]     ival_ff;
   logic [COUNT_W-1:0]    k_ff;
   logic [COUNT_W-1:0]    p_ff;
   logic [RAND_W-1:0]     rand_ff;
   logic [2*MUL_W-1:0]    prod_ff;
   logic [2*MUL_W-1:0]    lcg_lo_ff;
   logic [MUL_W-1:0]      lcg_x_ff;
   logic [2*MUL_W-1:0]    mid_p1_ff;
   logic [MID_W-1:0]      mid_q16_ff;
   logic [TERM_W-1:0]     term_ff;
   logic                  hit_ff;
   logic [ENERGY_W-1:0]   v_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [SUM_W-1:0]      best_sum_ff;
   logic [IVAL_W-1:0]     best_ival_ff;
   logic [TEMPO_Q4_W-1:0] tempo_res_ff;
   logic                  rsp_valid_ff;
   logic [TEMPO_Q4_W-1:0] rsp_tempo_ff;
   logic                  rsp_ovf_ff;

   // Datapath
   logic [MUL_W-1:0]      mul_a;
   logic [MUL_W-1:0]      mul_b;
   logic [2*MUL_W-1:0]    prod_in;
   logic [2*MUL_W-1:0]    mid_sum;
   logic [COUNT_W-1:0]    steps_eff;
   logic [IVAL_W-1:0]     q_sat;
   term_type              term;
   logic [POS_W-1:0]      mid_pos;
   logic [POS_W-1:0]      off_pos;
   logic [POS_W-1:0]      pos;
   logic                  in_range;
   logic [ENERGY_W-1:0]   fetched;
   logic [ENERGY_W:0]     diff;
   logic [ENERGY_W-1:0]   abs_diff;
   logic [SUM_W-1:0]      sum_term;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  sample_valid;
   logic                  finish_valid;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [ENERGY_W-1:0]   ram_wr_data;
   logic [ENERGY_W-1:0]   ram_rd_data;
   logic [CW-1:0]         energy_count;
   logic                  overflow;

   assign req_stall    = (state_ff != S_IDLE);
   assign sample_valid = req_valid && !req_stall && (req_command == CMD_SAMPLE);
   assign finish_valid = req_valid && !req_stall && (req_command == CMD_FINISH);

   tempo_est_meter #(
      .ENERGY_DEPTH(ENERGY_DEPTH),
      .DECIMATION  (DECIMATION)
   ) u_meter (
      .clock       (clock),
      .reset       (reset),
      .sample_valid(sample_valid),
      .sample      (req_audio_sample),
      .wr_en       (ram_wr_en),
      .wr_addr     (ram_wr_addr),
      .wr_data     (ram_wr_data),
      .energy_count(energy_count),
      .overflow    (overflow)
   );

   tempo_est_ram #(
      .WIDTH(ENERGY_W),
      .DEPTH(ENERGY_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(pos[POS_FRAC+AW-1:POS_FRAC]),
      .rd_data(ram_rd_data)
   );

   tempo_est_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign steps_eff = (steps_ff == '0) ? COUNT_W'(1) : steps_ff;

   // A tempo of zero divides by zero, which yields all ones and saturates.
   assign q_sat = (div_rsp.quotient > DD_W'(IVAL_MAX)) ? IVAL_MAX
                                                        : div_rsp.quotient[IVAL_W-1:0];

   always_comb begin
      div_req.start = (state_ff == S_DIV_GO);
      case (div_op_ff)
         OP_SLOW: begin
            div_req.dividend = IVAL_DIVIDEND;
            div_req.divisor  = DV_W'(slowest_ff);
         end
         OP_FAST: begin
            div_req.dividend = IVAL_DIVIDEND;
            div_req.divisor  = DV_W'(fastest_ff);
         end
         OP_STEP: begin
            div_req.dividend = DD_W'(slow_i_ff - fast_i_ff);
            div_req.divisor  = DV_W'(steps_eff);
         end
         default: begin
            div_req.dividend = TEMPO_DIVIDEND;
            div_req.divisor  = best_ival_ff;
         end
      endcase
   end

   // Shared multiplier: generator update in three products, probe center
   // in two.
   always_comb begin
      case (state_ff)
         S_LCG0: begin mul_a = rand_ff[MUL_W-1:0];        mul_b = LCG_MUL_LO; end
         S_LCG1: begin mul_a = rand_ff[MUL_W-1:0];        mul_b = LCG_MUL_HI; end
         S_LCG2: begin mul_a = rand_ff[RAND_W-1:MUL_W];   mul_b = LCG_MUL_LO; end
         S_MID0: begin mul_a = rand_ff[RAND_W-1:MUL_W];   mul_b = MUL_W'(energy_count); end
         S_MID1: begin mul_a = rand_ff[MUL_W-1:0];        mul_b = MUL_W'(energy_count); end
         default: begin mul_a = '0;                        mul_b = '0; end
      endcase
      prod_in = mul_a * mul_b;
      mid_sum = mid_p1_ff + {{MUL_W{1'b0}}, prod_ff[2*MUL_W-1:MUL_W]};
   end

   // Store position of the current term, in 1/2^18 store entries.
   always_comb begin
      term     = term_info(term_ff);
      mid_pos  = POS_W'({mid_q16_ff, 2'b00});
      off_pos  = POS_W'(ival_ff) << term.shift;
      if (term.center) begin
         pos = mid_pos;
      end else if (term.neg) begin
         pos = mid_pos - off_pos;
      end else begin
         pos = mid_pos + off_pos;
      end
      in_range = !pos[POS_W-1] && (pos[POS_W-1:POS_FRAC] < IDX_W'(energy_count));
      fetched  = hit_ff ? ram_rd_data : '0;
      diff     = {1'b0, fetched} - {1'b0, v_ff};
      abs_diff = diff[ENERGY_W] ? ENERGY_W'(-diff) : diff[ENERGY_W-1:0];
      sum_term = SUM_W'(abs_diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slowest_ff <= RST_SLOWEST;
         fastest_ff <= RST_FASTEST;
         steps_ff   <= RST_STEPS;
         probes_ff  <= RST_PROBES;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SLOWEST: slowest_ff <= csr_write_data[TEMPO_W-1:0];
            CSR_FASTEST: fastest_ff <= csr_write_data[TEMPO_W-1:0];
            CSR_STEPS:   steps_ff   <= csr_write_data;
            CSR_PROBES:  probes_ff  <= csr_write_data;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_op_ff    <= OP_SLOW;
         rand_ff      <= RAND_SEED;
         best_sum_ff  <= SUM_MAX;
         best_ival_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (finish_valid) begin
                  best_sum_ff  <= SUM_MAX;
                  best_ival_ff <= '0;
                  div_op_ff    <= OP_SLOW;
                  state_ff     <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_rsp.done) begin
                  case (div_op_ff)
                     OP_SLOW: begin
                        slow_i_ff <= q_sat;
                        div_op_ff <= OP_FAST;
                        state_ff  <= S_DIV_GO;
                     end
                     OP_FAST: begin
                        fast_i_ff <= q_sat;
                        if (q_sat > slow_i_ff) begin
                           // Reversed range: nothing is tested.
                           tempo_res_ff <= '0;
                           state_ff     <= S_DONE;
                        end else begin
                           div_op_ff <= OP_STEP;
                           state_ff  <= S_DIV_GO;
                        end
                     end
                     OP_STEP: begin
                        step_ff  <= div_rsp.quotient[IVAL_W-1:0];
                        k_ff     <= '0;
                        ival_ff  <= fast_i_ff;
                        state_ff <= S_INTERVAL;
                     end
                     default: begin
                        tempo_res_ff <= div_rsp.quotient[TEMPO_Q4_W-1:0];
                        state_ff     <= S_DONE;
                     end
                  endcase
               end
            end
            S_INTERVAL: begin
               sum_ff   <= '0;
               p_ff     <= '0;
               state_ff <= (probes_ff == '0) ? S_CLOSE : S_LCG0;
            end
            S_LCG0: begin
               term_ff  <= '0;
               state_ff <= S_LCG1;
            end
            S_LCG1: begin
               lcg_lo_ff <= prod_ff;
               state_ff  <= S_LCG2;
            end
            S_LCG2: begin
               lcg_x_ff <= prod_ff[MUL_W-1:0];
               state_ff <= S_LCG3;
            end
            S_LCG3: begin
               rand_ff  <= lcg_lo_ff + {lcg_x_ff + prod_ff[MUL_W-1:0], {MUL_W{1'b0}}}
                           + LCG_ADD;
               state_ff <= S_MID0;
            end
            S_MID0: begin
               state_ff <= S_MID1;
            end
            S_MID1: begin
               mid_p1_ff <= prod_ff;
               state_ff  <= S_MID2;
            end
            S_MID2: begin
               mid_q16_ff <= mid_sum[MID_W+7:8];
               state_ff   <= S_FADDR;
            end
            S_FADDR: begin
               hit_ff   <= in_range;
               state_ff <= S_FDATA;
            end
            S_FDATA: begin
               if (term.center) begin
                  v_ff <= fetched;
               end else if (term.penalty) begin
                  sum_ff <= sum_ff - sum_term;
               end else begin
                  sum_ff <= sum_ff + sum_term;
               end
               if (term_ff == TERM_W'(NUM_TERMS - 1)) begin
                  p_ff     <= p_ff + 1'b1;
                  state_ff <= (p_ff + 1'b1 == probes_ff) ? S_CLOSE : S_LCG0;
               end else begin
                  term_ff  <= term_ff + 1'b1;
                  state_ff <= S_FADDR;
               end
            end
            S_CLOSE: begin
               if ($signed(sum_ff) < $signed(best_sum_ff)) begin
                  best_sum_ff  <= sum_ff;
                  best_ival_ff <= ival_ff;
               end
               state_ff <= S_FINAL;
            end
            S_FINAL: begin
               if (k_ff == steps_eff) begin
                  if (best_ival_ff == '0) begin
                     tempo_res_ff <= '0;
                     state_ff     <= S_DONE;
                  end else begin
                     div_op_ff <= OP_TEMPO;
                     state_ff  <= S_DIV_GO;
                  end
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  ival_ff  <= ival_ff + step_ff;
                  state_ff <= S_INTERVAL;
               end
            end
            S_DONE: begin
               // Wait until the output register is free.
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_tempo_ff <= tempo_res_ff;
                  rsp_ovf_ff   <= overflow;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_tempo_q4         = rsp_tempo_ff;
   assign rsp_store_overflowed = rsp_ovf_ff;

`ifndef SYNTH
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside of a wait");

   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FADDR || state_ff == S_FDATA) |-> term_ff < TERM_W'(NUM_TERMS))
      else $error("probe term index out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside of the done state");

   a_ival_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INTERVAL |-> ival_ff <= slow_i_ff)
      else $error("tested interval beyond slowest interval");
`endif

endmodule

`default_nettype wire

// File: bench/tempo_estimator_core_tb.sv
// ----------------------------------------------------------------------------
// Tempo estimator core testbench
// Streams PCM samples and finish commands through the core. A local model of
// the peak meter, energy store and interval scan predicts every report, and
// each received report is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tempo_estimator_core_tb;
   import tempo_est_pkg::*;

   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  STORE_DEPTH = DEF_ENERGY_DEPTH;
   localparam int  DECIM       = DEF_DECIMATION;
   localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [TEMPO_Q4_W-1:0] tempo_q4;
      logic                  overflowed;
   } tempo_report_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_command;
   logic [SAMPLE_W-1:0]   req_audio_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [TEMPO_Q4_W-1:0] rsp_tempo_q4;
   logic                  rsp_store_overflowed;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   tempo_estimator_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_audio_sample(req_audio_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tempo_q4(rsp_tempo_q4),
      .rsp_store_overflowed(rsp_store_overflowed),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model state.
   logic [TEMPO_W-1:0]  slow_bpm, fast_bpm;
   logic [COUNT_W-1:0]  step_count, probe_count;
   longint unsigned     level_q9;
   int                  phase_count;
   logic [ENERGY_W-1:0] energy_mem [0:STORE_DEPTH-1];
   int                  energy_fill;
   logic                dropped_mark;
   longint unsigned     lcg_state;

   tempo_report_type expected_reports[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  reports_seen = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b1;
   int  hold_request = 0;

   function automatic longint unsigned beat_interval(logic [TEMPO_W-1:0] bpm);
      longint unsigned q;
      if (bpm == 0) return IVAL_MAX;
      q = 64'd1354752000 / bpm;
      return (q > IVAL_MAX) ? IVAL_MAX : q;
   endfunction

   function automatic longint energy_at(longint pos_q18);
      longint idx;
      if (pos_q18 < 0) return 0;
      idx = pos_q18 >>> POS_FRAC;
      if (idx >= energy_fill) return 0;
      return longint'(energy_mem[idx]);
   endfunction

   function automatic longint abs_diff(longint a, longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic longint probe_score(longint unsigned ival);
      longint unsigned hi, lo;
      longint mid, center, d;
      int mults[12] = '{-128, -64, -32, -16, -8, -4, 4, 8, 16, 32, 64, 128};
      int offs[4]   = '{-2, -1, 1, 2};
      lcg_state = (lcg_state * 64'h5DEECE66D + 64'hB) & MASK48;
      hi = (lcg_state >> 16) * longint'(energy_fill);
      lo = (lcg_state & 64'hFFFF) * longint'(energy_fill);
      mid = longint'(((hi + (lo >> 16)) >> 16) << 2);
      center = energy_at(mid);
      d = 0;
      foreach (mults[i]) d += abs_diff(energy_at(mid + mults[i] * longint'(ival)), center);
      foreach (offs[i])  d -= abs_diff(energy_at(mid + offs[i] * longint'(ival)), center);
      return d;
   endfunction

   function automatic logic [TEMPO_Q4_W-1:0] scan_tempo();
      longint unsigned slow_i, fast_i, stride, ival, best_ival;
      longint best, total;
      int steps;
      slow_i = beat_interval(slow_bpm);
      fast_i = beat_interval(fast_bpm);
      steps = (step_count == 0) ? 1 : int'(step_count);
      best = SUM_MAX;
      best_ival = 0;
      if (fast_i > slow_i) return '0;
      stride = (slow_i - fast_i) / steps;
      for (int k = 0; k <= steps; k++) begin
         ival = fast_i + k * stride;
         total = 0;
         for (int p = 0; p < int'(probe_count); p++) total += probe_score(ival);
         if (total < best) begin
            best = total;
            best_ival = ival;
         end
      end
      if (best_ival == 0) return '0;
      return TEMPO_Q4_W'(64'd21676032000 / best_ival);
   endfunction

   task automatic model_item(logic cmd, logic [SAMPLE_W-1:0] smp);
      longint unsigned mag, z;
      tempo_report_type r;
      if (cmd == CMD_FINISH) begin
         r.tempo_q4 = scan_tempo();
         r.overflowed = dropped_mark;
         expected_reports.push_back(r);
      end else begin
         mag = smp[SAMPLE_W-1] ? (64'h1000000 - smp) : smp;
         z = mag << LEVEL_FRAC;
         if (z > level_q9) level_q9 += (z - level_q9) >> 3;
         else level_q9 -= (level_q9 - z) >> 9;
         phase_count++;
         if (phase_count >= DECIM) begin
            phase_count = 0;
            if (energy_fill < STORE_DEPTH) begin
               energy_mem[energy_fill] = ENERGY_W'(level_q9 >> LEVEL_FRAC);
               energy_fill++;
            end else begin
               dropped_mark = 1'b1;
            end
         end
      end
   endtask

   task automatic send_item(logic cmd, logic [SAMPLE_W-1:0] smp);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_audio_sample <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model_item(cmd, smp);
      items_sent++;
   endtask

   // The core is idle once every report is in.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SLOWEST: slow_bpm = val[TEMPO_W-1:0];
         CSR_FASTEST: fast_bpm = val[TEMPO_W-1:0];
         CSR_STEPS:   step_count = val;
         CSR_PROBES:  probe_count = val;
         default: ;
      endcase
   endtask

   task automatic set_scan(int slow, int fast, int steps, int probes);
      write_reg(CSR_SLOWEST, CSR_DATA_W'(slow));
      write_reg(CSR_FASTEST, CSR_DATA_W'(fast));
      write_reg(CSR_STEPS, CSR_DATA_W'(steps));
      write_reg(CSR_PROBES, CSR_DATA_W'(probes));
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return SAMPLE_W'($urandom_range(0, 255)) - 24'd128;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Receiver: random stall bursts plus a requested long hold-off.
   int hold_left = 0;
   int burst_left = 0;
   always @(posedge clock) begin
      logic next_stall;
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      next_stall = 1'b0;
      if (reset) begin
         hold_left = 0;
         burst_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         next_stall = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(1, 15) - 1;
         next_stall = 1'b1;
      end
      rsp_stall <= next_stall;
   end

   // Report checker.
   always @(posedge clock) begin
      tempo_report_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected report tempo_q4=%0d overflowed=%0b",
                        rsp_tempo_q4, rsp_store_overflowed);
         end else begin
            e = expected_reports.pop_front();
            if (rsp_tempo_q4 !== e.tempo_q4 || rsp_store_overflowed !== e.overflowed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: report %0d expected tempo_q4=%0d overflowed=%0b, got %0d %0b",
                           reports_seen, e.tempo_q4, e.overflowed,
                           rsp_tempo_q4, rsp_store_overflowed);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_sample_extremes();
      logic [SAMPLE_W-1:0] pattern[8] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                                          24'h000001, 24'h800001, 24'h7FFFFE, 24'h555555};
      set_scan(72, 168, 2, 2);
      foreach (pattern[i]) send_item(CMD_SAMPLE, pattern[i]);
      send_item(CMD_FINISH, 24'h0);
   endtask

   task automatic test_special_cases();
      set_scan(0, 0, 2, 1);      // tempo zero on both ends
      send_item(CMD_FINISH, 24'h0);
      set_scan(0, 300, 3, 1);    // slow end saturated
      send_item(CMD_FINISH, 24'h0);
      set_scan(168, 72, 3, 2);   // reversed range
      send_item(CMD_FINISH, 24'h0);
      set_scan(72, 168, 0, 2);   // zero steps acts as one
      send_item(CMD_FINISH, 24'h0);
      set_scan(72, 168, 4, 0);   // zero probes
      send_item(CMD_FINISH, 24'h0);
      // Back to back finish transfers restart the scan each time.
      set_scan(60, 180, 2, 2);
      send_item(CMD_FINISH, 24'h0);
      send_item(CMD_FINISH, 24'h0);
   endtask

   task automatic test_random_stream(int phases, int per_phase);
      int slow, fast;
      for (int ph = 0; ph < phases; ph++) begin
         slow = $urandom_range(20, 300);
         fast = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300)
                                            : $urandom_range(slow, 300);
         set_scan(slow, fast, $urandom_range(0, 4), $urandom_range(0, 3));
         for (int i = 0; i < per_phase; i++) begin
            if (i == per_phase - 1 || $urandom_range(0, 24) == 0)
               send_item(CMD_FINISH, SAMPLE_W'($urandom));
            else
               send_item(CMD_SAMPLE, pick_sample());
         end
      end
   endtask

   task automatic test_backpressure();
      set_scan(90, 150, 1, 1);
      hold_request = 600;
      send_item(CMD_FINISH, 24'h0);
      send_item(CMD_FINISH, 24'h0);
      for (int i = 0; i < 20; i++) send_item(CMD_SAMPLE, pick_sample());
      send_item(CMD_FINISH, 24'h0);
   endtask

   task automatic test_scan_extremes();
      set_scan(20, 300, 4096, 0);
      send_item(CMD_FINISH, 24'h0);
      set_scan(20, 300, 1, 4096);
      send_item(CMD_FINISH, 24'h0);
      set_scan(300, 20, 8191, 8191);  // reversed, so nothing is scanned
      send_item(CMD_FINISH, 24'h0);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_SAMPLE;
      req_audio_sample <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_SLOWEST;
      csr_write_data <= '0;
      slow_bpm = RST_SLOWEST;
      fast_bpm = RST_FASTEST;
      step_count = RST_STEPS;
      probe_count = RST_PROBES;
      level_q9 = 0;
      phase_count = 0;
      energy_fill = 0;
      dropped_mark = 1'b0;
      lcg_state = RAND_SEED;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sample_extremes();
      test_special_cases();
      test_random_stream(10, 118);
      test_backpressure();
      test_scan_extremes();
      idle_on = 1'b0;
      test_random_stream(2, 118);

      wait_idle();
      repeat (50) @(posedge clock);
      if (expected_reports.size() != 0) mismatches++;
      $display("Sent %0d transfers, checked %0d tempo reports, %0d energy values stored.",
               items_sent, reports_seen, energy_fill);
      $display("Covered sample extremes, tempo zero, reversed range, zero steps and probes,");
      $display("repeated finish, long output hold-off and full-range scans.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
